/* rtl/sfsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfsp_pkg
// Shared constants for the subtitle frame shift parser: codes, characters,
// configuration indexes and default sizes.
// ----------------------------------------------------------------------------
package sfsp_pkg;

   localparam int DEFAULT_MAX_DIGITS = 8;
   localparam int DEFAULT_LINE_BITS  = 24;
   localparam int QUEUE_DEPTH        = 4;
   localparam int OFFSET_BITS        = 32;
   localparam int RATE_BITS          = 8;
   localparam int CSR_INDEX_BITS     = 2;

   // whole milliseconds: (x * ceil(2^38 / 1000)) >> 38, exact for any 32-bit x
   localparam int                       MS_RECIP_BITS  = 29;
   localparam logic [MS_RECIP_BITS-1:0] MS_RECIPROCAL  = 29'd274877907;
   localparam int                       MS_RECIP_SHIFT = 38;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATE   = 2'd1;
   localparam logic [RATE_BITS-1:0]      RESET_RATE = 8'd25;

   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_FORMAT   = 3'd1;
   localparam logic [2:0] ERR_ORDER    = 3'd2;
   localparam logic [2:0] ERR_END      = 3'd3;
   localparam logic [2:0] ERR_NEGATIVE = 3'd4;
   localparam logic [2:0] ERR_OVERFLOW = 3'd5;

   // commands from the parser to the emitter
   localparam logic [1:0] CMD_BYTE  = 2'd0;
   localparam logic [1:0] CMD_ERROR = 2'd1;
   localparam logic [1:0] CMD_EOI   = 2'd2;
   localparam logic [1:0] CMD_LINE  = 2'd3;

   // what an end of input emits before its done item
   localparam logic [1:0] PRE_NONE    = 2'd0;
   localparam logic [1:0] PRE_NEWLINE = 2'd1;
   localparam logic [1:0] PRE_ERROR   = 2'd2;

   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   localparam logic OP_DATA = 1'b0;
   localparam logic OP_EOI  = 1'b1;

endpackage
`default_nettype wire

/* rtl/sfsp_offset.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfsp_offset
// Configuration registers and the frame offset unit: rate times the whole
// milliseconds of the offset, by a reciprocal multiply and one rate multiply.
// ----------------------------------------------------------------------------
module sfsp_offset (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_valid,
   input  wire logic [sfsp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [sfsp_pkg::OFFSET_BITS-1:0]       csr_data,
   output logic                                        csr_ready,
   output logic signed [sfsp_pkg::OFFSET_BITS-1:0]     offset,
   output logic                                        offset_valid
);
   localparam int OB = sfsp_pkg::OFFSET_BITS;
   localparam int RB = sfsp_pkg::RATE_BITS;
   localparam int QB = 22;
   localparam int MB = sfsp_pkg::MS_RECIP_BITS;
   localparam int SH = sfsp_pkg::MS_RECIP_SHIFT;

   localparam logic [1:0] OS_IDLE = 2'd0;
   localparam logic [1:0] OS_LOAD = 2'd1;
   localparam logic [1:0] OS_DIV  = 2'd2;
   localparam logic [1:0] OS_MUL  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [OB-1:0]    off_us_ff, off_us_in;
   logic [RB-1:0]    rate_ff, rate_in;
   logic [OB-1:0]    dq_ff, dq_in;
   logic [QB-1:0]    quot_ff, quot_in;
   logic             neg_ff, neg_in;
   logic [OB-1:0]    offset_ff, offset_in;
   logic [OB+MB-1:0] recip;
   logic [QB+RB-1:0] prod;
   logic             wr;

   assign csr_ready    = 1'b1;
   assign wr           = csr_valid & csr_ready;
   assign offset       = $signed(offset_ff);
   assign offset_valid = (state_ff == OS_IDLE);
   assign recip        = dq_ff * sfsp_pkg::MS_RECIPROCAL;
   assign prod         = quot_ff * rate_ff;

   always_comb begin
      state_in  = state_ff;
      off_us_in = off_us_ff;
      rate_in   = rate_ff;
      dq_in     = dq_ff;
      quot_in   = quot_ff;
      neg_in    = neg_ff;
      offset_in = offset_ff;
      unique case (state_ff)
         OS_LOAD: begin
            neg_in   = off_us_ff[OB-1];
            dq_in    = off_us_ff[OB-1] ? (~off_us_ff + OB'(1)) : off_us_ff;
            state_in = OS_DIV;
         end
         OS_DIV: begin
            quot_in  = recip[SH +: QB];
            state_in = OS_MUL;
         end
         OS_MUL: begin
            offset_in = neg_ff ? (OB'(0) - OB'(prod)) : OB'(prod);
            state_in  = OS_IDLE;
         end
         default: begin
         end
      endcase
      if (wr) begin
         if (csr_index == sfsp_pkg::CSR_OFFSET) begin
            off_us_in = csr_data;
         end else if (csr_index == sfsp_pkg::CSR_RATE) begin
            rate_in = csr_data[RB-1:0];
         end
         state_in = OS_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= OS_IDLE;
         off_us_ff <= '0;
         rate_ff   <= sfsp_pkg::RESET_RATE;
         offset_ff <= '0;
      end else begin
         state_ff  <= state_in;
         off_us_ff <= off_us_in;
         rate_ff   <= rate_in;
         offset_ff <= offset_in;
      end
      dq_ff   <= dq_in;
      quot_ff <= quot_in;
      neg_ff  <= neg_in;
   end
endmodule
`default_nettype wire

/* rtl/sfsp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfsp_front
// Line parser: takes input bytes, tracks the line fields, runs the checks
// and queues at most one command per input for the emitter.
// ----------------------------------------------------------------------------
module sfsp_front #(
   parameter int MAX_DIGITS = sfsp_pkg::DEFAULT_MAX_DIGITS,
   parameter int LINE_BITS  = sfsp_pkg::DEFAULT_LINE_BITS,
   parameter int FRAME_BITS = $clog2(10**MAX_DIGITS),
   parameter int CMD_BITS   = 15 + LINE_BITS + 2*FRAME_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   input  wire logic                                in_operation,
   input  wire logic [7:0]                          in_byte,
   input  wire logic signed [sfsp_pkg::OFFSET_BITS-1:0] offset,
   output logic                                     cmd_push,
   output logic [CMD_BITS-1:0]                      cmd_data
);
   localparam int DCB = $clog2(MAX_DIGITS + 1);
   localparam int SB  = sfsp_pkg::OFFSET_BITS + 2;
   localparam longint LIMIT = 10**MAX_DIGITS - 1;

   localparam logic [2:0] PH_BRACE1 = 3'd0;
   localparam logic [2:0] PH_START  = 3'd1;
   localparam logic [2:0] PH_BRACE2 = 3'd2;
   localparam logic [2:0] PH_END    = 3'd3;
   localparam logic [2:0] PH_TEXT   = 3'd4;

   typedef struct packed {
      logic [1:0]            op;
      logic [1:0]            pre;
      logic [7:0]            data;
      logic [2:0]            code;
      logic [LINE_BITS-1:0]  line;
      logic [FRAME_BITS-1:0] s;
      logic [FRAME_BITS-1:0] e;
   } cmd_type;

   logic [2:0]            phase_ff, phase_in;
   logic [FRAME_BITS-1:0] start_ff, start_in, end_ff, end_in, prev_ff, prev_in;
   logic [DCB-1:0]        dcnt_ff, dcnt_in;
   logic                  have_ff, have_in, halted_ff, halted_in, open_ff, open_in;
   logic [LINE_BITS-1:0]  line_ff, line_in;
   cmd_type               cmd;
   logic                  digit;
   logic [FRAME_BITS-1:0] acc;
   logic [FRAME_BITS+3:0] mac;
   logic [DCB:0]          dnext;
   logic signed [SB-1:0]  off_x, s_sum, e_sum, lim;

   assign digit = (in_byte >= sfsp_pkg::CH_ZERO) && (in_byte <= sfsp_pkg::CH_NINE);
   assign acc   = (phase_ff == PH_START) ? start_ff : end_ff;
   assign mac   = ((FRAME_BITS+4)'(acc) * (FRAME_BITS+4)'(10)) + (FRAME_BITS+4)'(in_byte[3:0]);
   assign dnext = (DCB+1)'(dcnt_ff) + (DCB+1)'(1);
   assign off_x = SB'(offset);
   assign s_sum = $signed(SB'(start_ff)) + off_x;
   assign e_sum = $signed(SB'(end_ff)) + off_x;
   assign lim   = SB'(LIMIT);
   assign cmd_data = cmd;

   always_comb begin
      phase_in  = phase_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      prev_in   = prev_ff;
      dcnt_in   = dcnt_ff;
      have_in   = have_ff;
      halted_in = halted_ff;
      open_in   = open_ff;
      line_in   = line_ff;
      cmd_push  = 1'b0;
      cmd       = '0;
      cmd.line  = line_ff;
      cmd.s     = FRAME_BITS'(s_sum);
      cmd.e     = FRAME_BITS'(e_sum);
      cmd.data  = in_byte;
      if (in_valid) begin
         if (in_operation == sfsp_pkg::OP_EOI) begin
            cmd_push = 1'b1;
            cmd.op   = sfsp_pkg::CMD_EOI;
            cmd.pre  = sfsp_pkg::PRE_NONE;
            if (!halted_ff) begin
               if (phase_ff == PH_TEXT) begin
                  cmd.pre = sfsp_pkg::PRE_NEWLINE;
               end else if (open_ff) begin
                  cmd.pre  = sfsp_pkg::PRE_ERROR;
                  cmd.code = sfsp_pkg::ERR_FORMAT;
               end
            end
            phase_in  = PH_BRACE1;
            start_in  = '0;
            end_in    = '0;
            dcnt_in   = '0;
            prev_in   = '0;
            have_in   = 1'b0;
            line_in   = LINE_BITS'(1);
            halted_in = 1'b0;
            open_in   = 1'b0;
         end else if (!halted_ff) begin
            cmd_push = 1'b1;
            cmd.op   = sfsp_pkg::CMD_ERROR;
            cmd.code = sfsp_pkg::ERR_FORMAT;
            if (in_byte == sfsp_pkg::CH_NEWLINE) begin
               if (phase_ff == PH_TEXT) begin
                  cmd.op   = sfsp_pkg::CMD_BYTE;
                  phase_in = PH_BRACE1;
                  open_in  = 1'b0;
                  if (line_ff != '1) begin
                     line_in = line_ff + LINE_BITS'(1);
                  end
               end
            end else begin
               open_in = 1'b1;
               unique case (phase_ff)
                  PH_BRACE1, PH_BRACE2: begin
                     if (in_byte == sfsp_pkg::CH_LBRACE) begin
                        cmd_push = 1'b0;
                        dcnt_in  = '0;
                        if (phase_ff == PH_BRACE1) begin
                           start_in = '0;
                           phase_in = PH_START;
                        end else begin
                           end_in   = '0;
                           phase_in = PH_END;
                        end
                     end
                  end
                  PH_START, PH_END: begin
                     if (digit) begin
                        if (dnext > (DCB+1)'(MAX_DIGITS)) begin
                           cmd.code = sfsp_pkg::ERR_OVERFLOW;
                        end else begin
                           cmd_push = 1'b0;
                           dcnt_in  = DCB'(dnext);
                           if (phase_ff == PH_START) begin
                              start_in = FRAME_BITS'(mac);
                           end else begin
                              end_in = FRAME_BITS'(mac);
                           end
                        end
                     end else if (in_byte == sfsp_pkg::CH_RBRACE && dcnt_ff != '0) begin
                        if (phase_ff == PH_START) begin
                           if (s_sum < 0) begin
                              cmd.code = sfsp_pkg::ERR_NEGATIVE;
                           end else if (have_ff && start_ff < prev_ff) begin
                              cmd.code = sfsp_pkg::ERR_ORDER;
                           end else begin
                              cmd_push = 1'b0;
                              prev_in  = start_ff;
                              have_in  = 1'b1;
                              phase_in = PH_BRACE2;
                           end
                        end else begin
                           if (start_ff >= end_ff) begin
                              cmd.code = sfsp_pkg::ERR_END;
                           end else if (e_sum > lim) begin
                              cmd.code = sfsp_pkg::ERR_OVERFLOW;
                           end else begin
                              cmd.op   = sfsp_pkg::CMD_LINE;
                              phase_in = PH_TEXT;
                           end
                        end
                     end
                  end
                  default: begin
                     cmd.op = sfsp_pkg::CMD_BYTE;
                  end
               endcase
            end
            if (cmd_push && cmd.op == sfsp_pkg::CMD_ERROR) begin
               halted_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_BRACE1;
         start_ff  <= '0;
         end_ff    <= '0;
         prev_ff   <= '0;
         dcnt_ff   <= '0;
         have_ff   <= 1'b0;
         halted_ff <= 1'b0;
         open_ff   <= 1'b0;
         line_ff   <= LINE_BITS'(1);
      end else begin
         phase_ff  <= phase_in;
         start_ff  <= start_in;
         end_ff    <= end_in;
         prev_ff   <= prev_in;
         dcnt_ff   <= dcnt_in;
         have_ff   <= have_in;
         halted_ff <= halted_in;
         open_ff   <= open_in;
         line_ff   <= line_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/sfsp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfsp_queue
// Short command queue between the parser and the emitter.
// ----------------------------------------------------------------------------
module sfsp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sfsp_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CB = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PB-1:0]    wp_ff, rp_ff;
   logic [CB-1:0]    count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CB'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= push_data;
      end
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wp_ff <= (wp_ff == PB'(DEPTH - 1)) ? '0 : wp_ff + PB'(1);
         end
         if (do_pop) begin
            rp_ff <= (rp_ff == PB'(DEPTH - 1)) ? '0 : rp_ff + PB'(1);
         end
         count_ff <= count_ff + CB'(do_push) - CB'(do_pop);
      end
   end
endmodule
`default_nettype wire

/* rtl/sfsp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfsp_back
// Emitter: turns queued commands into result items, converting frame
// numbers to decimal with a bit-serial binary to BCD pass.
// ----------------------------------------------------------------------------
module sfsp_back #(
   parameter int MAX_DIGITS = sfsp_pkg::DEFAULT_MAX_DIGITS,
   parameter int LINE_BITS  = sfsp_pkg::DEFAULT_LINE_BITS,
   parameter int FRAME_BITS = $clog2(10**MAX_DIGITS),
   parameter int CMD_BITS   = 15 + LINE_BITS + 2*FRAME_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_empty,
   input  wire logic [CMD_BITS-1:0]  cmd_data,
   output logic                      cmd_pop,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_out_byte,
   output logic [2:0]                rsp_error_code,
   output logic [LINE_BITS-1:0]      rsp_line_number,
   output logic                      rsp_last
);
   localparam int CNB = $clog2(FRAME_BITS + 1);
   localparam int DGB = $clog2(MAX_DIGITS + 1);
   localparam int BB  = 4 * MAX_DIGITS;

   localparam logic [2:0] BK_IDLE   = 3'd0;
   localparam logic [2:0] BK_DONE   = 3'd1;
   localparam logic [2:0] BK_CONV   = 3'd2;
   localparam logic [2:0] BK_DIGITS = 3'd3;
   localparam logic [2:0] BK_CLOSE  = 3'd4;
   localparam logic [2:0] BK_OPEN2  = 3'd5;

   typedef struct packed {
      logic [1:0]            op;
      logic [1:0]            pre;
      logic [7:0]            data;
      logic [2:0]            code;
      logic [LINE_BITS-1:0]  line;
      logic [FRAME_BITS-1:0] s;
      logic [FRAME_BITS-1:0] e;
   } cmd_type;

   cmd_type               head;
   logic [2:0]            state_ff, state_in;
   logic [FRAME_BITS-1:0] e_ff, e_in;
   logic [FRAME_BITS-1:0] bin_ff, bin_in;
   logic [BB-1:0]         bcd_ff, bcd_in, bcd_adj;
   logic [CNB-1:0]        cnt_ff, cnt_in;
   logic [DGB-1:0]        dig_ff, dig_in;
   logic                  started_ff, started_in, second_ff, second_in;
   logic                  valid_ff, valid_in;
   logic [1:0]            kind_ff, kind_in;
   logic [7:0]            byte_ff, byte_in;
   logic [2:0]            code_ff, code_in;
   logic [LINE_BITS-1:0]  line_ff, line_in;
   logic                  last_ff, last_in;
   logic                  load;
   logic [3:0]            cur;

   assign head            = cmd_data;
   assign load            = ~valid_ff | rsp_pop;
   assign rsp_empty       = ~valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_error_code  = code_ff;
   assign rsp_line_number = line_ff;
   assign rsp_last        = last_ff;
   assign cur             = bcd_ff[4*dig_ff +: 4];

   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                       : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      state_in   = state_ff;
      e_in       = e_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      cnt_in     = cnt_ff;
      dig_in     = dig_ff;
      started_in = started_ff;
      second_in  = second_ff;
      valid_in   = valid_ff & ~rsp_pop;
      kind_in    = kind_ff;
      byte_in    = byte_ff;
      code_in    = code_ff;
      line_in    = line_ff;
      last_in    = last_ff;
      cmd_pop    = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty && load) begin
               cmd_pop  = 1'b1;
               valid_in = 1'b1;
               kind_in  = sfsp_pkg::KIND_TEXT;
               byte_in  = '0;
               code_in  = sfsp_pkg::ERR_NONE;
               line_in  = '0;
               last_in  = 1'b1;
               case (head.op)
                  sfsp_pkg::CMD_BYTE: begin
                     byte_in = head.data;
                  end
                  sfsp_pkg::CMD_ERROR: begin
                     kind_in = sfsp_pkg::KIND_ERROR;
                     code_in = head.code;
                     line_in = head.line;
                  end
                  sfsp_pkg::CMD_EOI: begin
                     if (head.pre == sfsp_pkg::PRE_NEWLINE) begin
                        byte_in  = sfsp_pkg::CH_NEWLINE;
                        last_in  = 1'b0;
                        state_in = BK_DONE;
                     end else if (head.pre == sfsp_pkg::PRE_ERROR) begin
                        kind_in  = sfsp_pkg::KIND_ERROR;
                        code_in  = head.code;
                        line_in  = head.line;
                        last_in  = 1'b0;
                        state_in = BK_DONE;
                     end else begin
                        kind_in = sfsp_pkg::KIND_DONE;
                     end
                  end
                  default: begin
                     byte_in   = sfsp_pkg::CH_LBRACE;
                     last_in   = 1'b0;
                     bin_in    = head.s;
                     e_in      = head.e;
                     bcd_in    = '0;
                     cnt_in    = '0;
                     second_in = 1'b0;
                     state_in  = BK_CONV;
                  end
               endcase
            end
         end
         BK_DONE: begin
            if (load) begin
               valid_in = 1'b1;
               kind_in  = sfsp_pkg::KIND_DONE;
               byte_in  = '0;
               code_in  = sfsp_pkg::ERR_NONE;
               line_in  = '0;
               last_in  = 1'b1;
               state_in = BK_IDLE;
            end
         end
         BK_CONV: begin
            bcd_in = {bcd_adj[BB-2:0], bin_ff[FRAME_BITS-1]};
            bin_in = bin_ff << 1;
            cnt_in = cnt_ff + CNB'(1);
            if (cnt_ff == CNB'(FRAME_BITS - 1)) begin
               dig_in     = DGB'(MAX_DIGITS - 1);
               started_in = 1'b0;
               state_in   = BK_DIGITS;
            end
         end
         BK_DIGITS: begin
            if (cur == 4'd0 && !started_ff && dig_ff != '0) begin
               dig_in = dig_ff - DGB'(1);
            end else if (load) begin
               valid_in   = 1'b1;
               kind_in    = sfsp_pkg::KIND_TEXT;
               byte_in    = sfsp_pkg::CH_ZERO | {4'd0, cur};
               last_in    = 1'b0;
               started_in = 1'b1;
               if (dig_ff == '0) begin
                  state_in = BK_CLOSE;
               end else begin
                  dig_in = dig_ff - DGB'(1);
               end
            end
         end
         BK_CLOSE: begin
            if (load) begin
               valid_in = 1'b1;
               byte_in  = sfsp_pkg::CH_RBRACE;
               last_in  = second_ff;
               state_in = second_ff ? BK_IDLE : BK_OPEN2;
            end
         end
         BK_OPEN2: begin
            if (load) begin
               valid_in  = 1'b1;
               byte_in   = sfsp_pkg::CH_LBRACE;
               last_in   = 1'b0;
               bin_in    = e_ff;
               bcd_in    = '0;
               cnt_in    = '0;
               second_in = 1'b1;
               state_in  = BK_CONV;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      e_ff       <= e_in;
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      cnt_ff     <= cnt_in;
      dig_ff     <= dig_in;
      started_ff <= started_in;
      second_ff  <= second_in;
      kind_ff    <= kind_in;
      byte_ff    <= byte_in;
      code_ff    <= code_in;
      line_ff    <= line_in;
      last_ff    <= last_in;
   end
endmodule
`default_nettype wire

/* rtl/subtitle_frame_shift_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// subtitle_frame_shift_parser
// Shifts the frame numbers of MicroDVD subtitle lines by a configured offset.
// ----------------------------------------------------------------------------
// Text bytes and braces are taken one per cycle while the command queue has
// room; each accepted input is one transfer and queues at most one command
// (digits and opening braces only update the parser). A line's closing brace
// starts a burst of output: each frame number is converted by a bit-serial
// binary to BCD pass over FRAME_BITS bits (27 at eight digits), then scanned
// digit position by digit position, leading zeros included. The input reports
// full while the queue is full, and after a configuration write while the
// offset unit steps through its load, divide and multiply states to recompute
// rate times whole milliseconds.
module subtitle_frame_shift_parser #(
   parameter int MAX_DIGITS = sfsp_pkg::DEFAULT_MAX_DIGITS,
   parameter int LINE_BITS  = sfsp_pkg::DEFAULT_LINE_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic                                req_operation,
   input  wire logic [7:0]                          req_data_byte,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [1:0]                               rsp_kind,
   output logic [7:0]                               rsp_out_byte,
   output logic [2:0]                               rsp_error_code,
   output logic [LINE_BITS-1:0]                     rsp_line_number,
   output logic                                     rsp_last,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [sfsp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [sfsp_pkg::OFFSET_BITS-1:0]    csr_data
);
   localparam int FRAME_BITS = $clog2(10**MAX_DIGITS);
   localparam int CMD_BITS   = 15 + LINE_BITS + 2*FRAME_BITS;

   logic signed [sfsp_pkg::OFFSET_BITS-1:0] offset;
   logic                  offset_valid;
   logic                  q_full, q_empty, q_push, q_pop;
   logic [CMD_BITS-1:0]   q_in, q_out;
   logic                  accept;

   assign req_full = q_full | ~offset_valid;
   assign accept   = req_push & ~req_full;

   sfsp_offset u_offset (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .csr_ready    (csr_ready),
      .offset       (offset),
      .offset_valid (offset_valid)
   );

   sfsp_front #(
      .MAX_DIGITS (MAX_DIGITS),
      .LINE_BITS  (LINE_BITS),
      .FRAME_BITS (FRAME_BITS),
      .CMD_BITS   (CMD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .in_operation (req_operation),
      .in_byte      (req_data_byte),
      .offset       (offset),
      .cmd_push     (q_push),
      .cmd_data     (q_in)
   );

   sfsp_queue #(
      .WIDTH (CMD_BITS),
      .DEPTH (sfsp_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   sfsp_back #(
      .MAX_DIGITS (MAX_DIGITS),
      .LINE_BITS  (LINE_BITS),
      .FRAME_BITS (FRAME_BITS),
      .CMD_BITS   (CMD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_empty       (q_empty),
      .cmd_data        (q_out),
      .cmd_pop         (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_error_code  (rsp_error_code),
      .rsp_line_number (rsp_line_number),
      .rsp_last        (rsp_last)
   );
endmodule
`default_nettype wire

/* sim/subtitle_frame_shift_parser_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtitle_frame_shift_parser_checker
// Watches the input, result and register channels of the frame shift parser,
// predicts every result of each accepted input and compares in order.
// ----------------------------------------------------------------------------
module subtitle_frame_shift_parser_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   input  wire logic                                req_full,
   input  wire logic                                req_operation,
   input  wire logic [7:0]                          req_data_byte,
   input  wire logic                                rsp_empty,
   input  wire logic                                rsp_pop,
   input  wire logic [1:0]                          rsp_kind,
   input  wire logic [7:0]                          rsp_out_byte,
   input  wire logic [2:0]                          rsp_error_code,
   input  wire logic [23:0]                         rsp_line_number,
   input  wire logic                                rsp_last,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_ready,
   input  wire logic [sfsp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [sfsp_pkg::OFFSET_BITS-1:0]    csr_data,
   output int                                       fail_count,
   output int                                       pending_count
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_byte;
      logic [2:0]  error_code;
      logic [23:0] line_number;
      logic        last;
   } shifted_item_type;

   localparam logic [2:0] PH_OPEN_START   = 3'd0;
   localparam logic [2:0] PH_START_DIGITS = 3'd1;
   localparam logic [2:0] PH_OPEN_END     = 3'd2;
   localparam logic [2:0] PH_END_DIGITS   = 3'd3;
   localparam logic [2:0] PH_TEXT         = 3'd4;

   localparam longint DIGIT_LIMIT = 64'd99999999;

   shifted_item_type expected_items[$];

   logic signed [31:0] shift_us;
   logic [7:0]         rate;
   logic [2:0]         phase;
   longint             start_frame, end_frame, prev_start;
   int                 digits;
   logic               have_prev, halted, line_open;
   logic [23:0]        line_no;

   assign pending_count = expected_items.size();

   function automatic longint frame_shift();
      longint ms;
      ms = longint'(shift_us) / 1000;
      return longint'(rate) * ms;
   endfunction

   task automatic push_item(logic [1:0] k, logic [7:0] b, logic [2:0] e, logic [23:0] ln);
      shifted_item_type it;
      it = '{kind: k, out_byte: b, error_code: e, line_number: ln, last: 1'b0};
      expected_items.push_back(it);
   endtask

   task automatic push_decimal(longint v);
      logic [7:0] d[$];
      do begin
         d.push_front(sfsp_pkg::CH_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (d[i]) push_item(sfsp_pkg::KIND_TEXT, d[i], sfsp_pkg::ERR_NONE, '0);
   endtask

   task automatic report_error(logic [2:0] code);
      push_item(sfsp_pkg::KIND_ERROR, 8'd0, code, line_no);
      halted = 1'b1;
   endtask

   task automatic clear_parser();
      phase = PH_OPEN_START;
      start_frame = 0; end_frame = 0; prev_start = 0;
      digits = 0; have_prev = 0; halted = 0; line_open = 0;
      line_no = 24'd1;
   endtask

   task automatic take_byte(logic [7:0] b);
      longint s, e;
      logic is_digit;
      is_digit = b >= sfsp_pkg::CH_ZERO && b <= sfsp_pkg::CH_NINE;
      line_open = 1'b1;
      case (phase)
         PH_OPEN_START, PH_OPEN_END: begin
            if (b != sfsp_pkg::CH_LBRACE) begin
               report_error(sfsp_pkg::ERR_FORMAT);
            end else begin
               digits = 0;
               if (phase == PH_OPEN_START) begin
                  start_frame = 0;
                  phase = PH_START_DIGITS;
               end else begin
                  end_frame = 0;
                  phase = PH_END_DIGITS;
               end
            end
         end
         PH_START_DIGITS, PH_END_DIGITS: begin
            if (is_digit) begin
               digits++;
               if (digits > sfsp_pkg::DEFAULT_MAX_DIGITS) begin
                  report_error(sfsp_pkg::ERR_OVERFLOW);
               end else if (phase == PH_START_DIGITS) begin
                  start_frame = start_frame * 10 + (b - sfsp_pkg::CH_ZERO);
               end else begin
                  end_frame = end_frame * 10 + (b - sfsp_pkg::CH_ZERO);
               end
            end else if (b != sfsp_pkg::CH_RBRACE || digits == 0) begin
               report_error(sfsp_pkg::ERR_FORMAT);
            end else if (phase == PH_START_DIGITS) begin
               if (start_frame + frame_shift() < 0) begin
                  report_error(sfsp_pkg::ERR_NEGATIVE);
               end else if (have_prev && start_frame < prev_start) begin
                  report_error(sfsp_pkg::ERR_ORDER);
               end else begin
                  prev_start = start_frame;
                  have_prev = 1'b1;
                  phase = PH_OPEN_END;
               end
            end else begin
               s = start_frame + frame_shift();
               e = end_frame + frame_shift();
               if (start_frame >= end_frame) begin
                  report_error(sfsp_pkg::ERR_END);
               end else if (e > DIGIT_LIMIT) begin
                  report_error(sfsp_pkg::ERR_OVERFLOW);
               end else begin
                  push_item(sfsp_pkg::KIND_TEXT, sfsp_pkg::CH_LBRACE, sfsp_pkg::ERR_NONE, '0);
                  push_decimal(s);
                  push_item(sfsp_pkg::KIND_TEXT, sfsp_pkg::CH_RBRACE, sfsp_pkg::ERR_NONE, '0);
                  push_item(sfsp_pkg::KIND_TEXT, sfsp_pkg::CH_LBRACE, sfsp_pkg::ERR_NONE, '0);
                  push_decimal(e);
                  push_item(sfsp_pkg::KIND_TEXT, sfsp_pkg::CH_RBRACE, sfsp_pkg::ERR_NONE, '0);
                  phase = PH_TEXT;
               end
            end
         end
         default: push_item(sfsp_pkg::KIND_TEXT, b, sfsp_pkg::ERR_NONE, '0);
      endcase
   endtask

   task automatic predict_input(logic op, logic [7:0] b);
      int size_at_entry;
      size_at_entry = expected_items.size();
      if (op == sfsp_pkg::OP_EOI) begin
         if (!halted) begin
            if (phase == PH_TEXT)
               push_item(sfsp_pkg::KIND_TEXT, sfsp_pkg::CH_NEWLINE, sfsp_pkg::ERR_NONE, '0);
            else if (line_open) report_error(sfsp_pkg::ERR_FORMAT);
         end
         push_item(sfsp_pkg::KIND_DONE, 8'd0, sfsp_pkg::ERR_NONE, '0);
         clear_parser();
      end else if (!halted) begin
         if (b == sfsp_pkg::CH_NEWLINE && phase == PH_TEXT) begin
            push_item(sfsp_pkg::KIND_TEXT, sfsp_pkg::CH_NEWLINE, sfsp_pkg::ERR_NONE, '0);
            if (line_no != '1) line_no++;
            phase = PH_OPEN_START;
            line_open = 1'b0;
         end else if (b == sfsp_pkg::CH_NEWLINE) begin
            report_error(sfsp_pkg::ERR_FORMAT);
         end else begin
            take_byte(b);
         end
      end
      if (expected_items.size() > size_at_entry)
         expected_items[expected_items.size()-1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      shifted_item_type exp_item;
      if (reset) begin
         shift_us <= '0;
         rate <= sfsp_pkg::RESET_RATE;
         clear_parser();
         expected_items.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == sfsp_pkg::CSR_OFFSET) shift_us <= csr_data;
            else if (csr_index == sfsp_pkg::CSR_RATE) rate <= csr_data[7:0];
         end
         if (req_push && !req_full) predict_input(req_operation, req_data_byte);
         if (rsp_pop && !rsp_empty) begin
            if (expected_items.size() == 0) begin
               $error("unexpected result transfer: kind %0d", rsp_kind);
               fail_count <= fail_count + 1;
            end else begin
               exp_item = expected_items.pop_front();
               if (exp_item.kind !== rsp_kind || exp_item.out_byte !== rsp_out_byte ||
                   exp_item.error_code !== rsp_error_code ||
                   exp_item.line_number !== rsp_line_number || exp_item.last !== rsp_last)
                  fail_count <= fail_count + 1;
               if (exp_item.kind !== rsp_kind)
                  $error("kind: expected %0d actual %0d", exp_item.kind, rsp_kind);
               if (exp_item.out_byte !== rsp_out_byte)
                  $error("out_byte: expected %0d actual %0d", exp_item.out_byte, rsp_out_byte);
               if (exp_item.error_code !== rsp_error_code)
                  $error("error_code: expected %0d actual %0d",
                         exp_item.error_code, rsp_error_code);
               if (exp_item.line_number !== rsp_line_number)
                  $error("line_number: expected %0d actual %0d",
                         exp_item.line_number, rsp_line_number);
               if (exp_item.last !== rsp_last)
                  $error("last: expected %0d actual %0d", exp_item.last, rsp_last);
            end
         end
      end
   end

endmodule

/* sim/subtitle_frame_shift_parser_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtitle_frame_shift_parser_test
// Drives subtitle lines, broken lines, noise and end of input markers through
// the parser under several offset and frame rate settings with random idling
// on both sides; the checker compares every result transfer.
// ----------------------------------------------------------------------------
module subtitle_frame_shift_parser_test;

   logic                                clock;
   logic                                reset;
   logic                                req_push;
   logic                                req_full;
   logic                                req_operation;
   logic [7:0]                          req_data_byte;
   logic                                rsp_empty;
   logic                                rsp_pop;
   logic [1:0]                          rsp_kind;
   logic [7:0]                          rsp_out_byte;
   logic [2:0]                          rsp_error_code;
   logic [23:0]                         rsp_line_number;
   logic                                rsp_last;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [sfsp_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [sfsp_pkg::OFFSET_BITS-1:0]    csr_data;
   int                                  fail_count;
   int                                  pending_count;
   logic                                sender_busy_idle;
   logic                                receiver_calm;
   logic                                receiver_hold;
   int                                  item_total;

   subtitle_frame_shift_parser u_top (.*);

   subtitle_frame_shift_parser_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: random pops, a calm stretch, and one long hold-off
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (receiver_hold) rsp_pop <= 1'b0;
         else if (receiver_calm) rsp_pop <= 1'b1;
         else rsp_pop <= ($urandom_range(99) >= 24);
      end
   end

   task automatic send_item(logic op, logic [7:0] b);
      while (!sender_busy_idle && $urandom_range(99) < 24) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_operation <= op;
      req_data_byte <= b;
      do @(posedge clock); while (req_full);
      item_total++;
   endtask

   task automatic send_text(string s);
      foreach (s[i]) send_item(sfsp_pkg::OP_DATA, s[i]);
   endtask

   task automatic send_line(int unsigned s, int unsigned e, int text_len, bit nl);
      send_text($sformatf("{%0d}{%0d}", s, e));
      repeat (text_len) send_item(sfsp_pkg::OP_DATA, 8'($urandom_range(8'h20, 8'h7E)));
      if (nl) send_item(sfsp_pkg::OP_DATA, sfsp_pkg::CH_NEWLINE);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [sfsp_pkg::CSR_INDEX_BITS-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_session();
      int unsigned s;
      int lines;
      lines = $urandom_range(1, 5);
      s = $urandom_range(0, 3000);
      for (int i = 0; i < lines; i++) begin
         case ($urandom_range(9))
            0: send_text($sformatf("{%0d}{%0d}", s, s));
            1: send_text("{1x");
            2: send_item(sfsp_pkg::OP_DATA, 8'($urandom));
            3: send_line(s + 10 > 20 ? s - 20 : 0, s + 50, 1, 1);
            default: begin
               send_line(s, s + $urandom_range(1, 500), $urandom_range(0, 6),
                         $urandom_range(3) != 0);
               s = s + $urandom_range(0, 200);
            end
         endcase
      end
      send_item(sfsp_pkg::OP_EOI, 8'($urandom));
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_operation = sfsp_pkg::OP_DATA;
      req_data_byte = '0;
      csr_valid = 1'b0;
      csr_index = sfsp_pkg::CSR_OFFSET;
      csr_data = '0;
      sender_busy_idle = 1'b0;
      receiver_calm = 1'b0;
      receiver_hold = 1'b0;
      item_total = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default settings
      send_line(0, 1, 2, 1);
      send_line(99999999, 99999999, 0, 1);
      send_item(sfsp_pkg::OP_EOI, 8'hFF);
      send_text("{123456789");
      send_item(sfsp_pkg::OP_DATA, 8'h80);
      send_item(sfsp_pkg::OP_EOI, 8'h00);
      send_text("{5}{3}");
      send_item(sfsp_pkg::OP_EOI, 8'h00);
      send_line(50, 60, 0, 1);
      send_text("{40}");
      send_item(sfsp_pkg::OP_EOI, 8'h00);
      drain();

      write_reg(sfsp_pkg::CSR_OFFSET, 32'h8000_0000);
      write_reg(sfsp_pkg::CSR_RATE, 32'd240);
      send_text("{0}");
      send_item(sfsp_pkg::OP_EOI, 8'h00);
      send_item(sfsp_pkg::OP_DATA, sfsp_pkg::CH_NEWLINE);
      send_item(sfsp_pkg::OP_EOI, 8'h00);
      send_text("{}");
      send_item(sfsp_pkg::OP_EOI, 8'h00);
      drain();

      write_reg(sfsp_pkg::CSR_OFFSET, 32'h7FFF_FFFF);
      write_reg(sfsp_pkg::CSR_RATE, 32'd1);
      send_text("{0}{1}");
      send_item(sfsp_pkg::OP_EOI, 8'h00);
      send_item(sfsp_pkg::OP_EOI, 8'h00);
      drain();

      // random phases under several settings
      for (int phase_no = 0; phase_no < 5; phase_no++) begin
         case (phase_no)
            0: begin
               write_reg(sfsp_pkg::CSR_OFFSET, 32'd0);
               write_reg(sfsp_pkg::CSR_RATE, 32'd0);
            end
            1: begin
               write_reg(sfsp_pkg::CSR_OFFSET, 32'd40_999);
               write_reg(sfsp_pkg::CSR_RATE, 32'd25);
            end
            2: begin
               write_reg(sfsp_pkg::CSR_OFFSET, -32'sd2_500_500);
               write_reg(sfsp_pkg::CSR_RATE, 32'd30);
            end
            3: begin
               write_reg(sfsp_pkg::CSR_OFFSET, $urandom);
               write_reg(sfsp_pkg::CSR_RATE, 32'($urandom_range(255)));
            end
            default: begin
               write_reg(sfsp_pkg::CSR_OFFSET, -32'sd999);
               write_reg(sfsp_pkg::CSR_RATE, 32'd240);
            end
         endcase
         if (phase_no == 1) begin
            receiver_hold <= 1'b1;
            fork
               begin
                  repeat (300) @(posedge clock);
                  receiver_hold <= 1'b0;
               end
               begin
                  send_line(0, 10, 20, 1);
                  random_session();
                  req_push <= 1'b0;
               end
            join
         end
         sender_busy_idle = (phase_no == 2);
         receiver_calm = (phase_no == 2);
         while (item_total < 70 * (phase_no + 1)) random_session();
         sender_busy_idle = 1'b0;
         receiver_calm = 1'b0;
         drain();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* subtitle_frame_shift_parser.f */
rtl/sfsp_pkg.sv
rtl/sfsp_offset.sv
rtl/sfsp_front.sv
rtl/sfsp_queue.sv
rtl/sfsp_back.sv
rtl/subtitle_frame_shift_parser.sv
sim/subtitle_frame_shift_parser_checker.sv
sim/subtitle_frame_shift_parser_test.sv
